// File: rtl/core/esc_pkg.sv
// shared constants, codes and helpers for the sensor compensation core
`timescale 1ns / 1ps

package esc_pkg;

    localparam int DataWidth = 64;
    localparam int AddrWidth = 6;

    // operation codes of an input transfer
    localparam logic [1:0] OP_TEMP = 2'd0;
    localparam logic [1:0] OP_PRES = 2'd1;
    localparam logic [1:0] OP_HUM  = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // register indexes
    localparam logic [2:0] REG_TEMP_CAL = 3'd0;
    localparam logic [2:0] REG_PRES_A   = 3'd1;
    localparam logic [2:0] REG_PRES_B   = 3'd2;
    localparam logic [2:0] REG_PRES_C   = 3'd3;
    localparam logic [2:0] REG_HUM_CAL  = 3'd4;

    localparam logic [63:0] C_PRES_OFS  = 64'd128000;
    localparam logic [63:0] C_PRES_FULL = 64'd1048576;
    localparam logic [63:0] C_PRES_MUL  = 64'd3125;
    localparam logic [63:0] C_HUM_OFS   = 64'd76800;
    localparam logic [63:0] C_HUM_RND   = 64'd16384;
    localparam logic [63:0] C_HUM_BIAS  = 64'd2097152;
    localparam logic [63:0] C_HUM_RND2  = 64'd8192;
    localparam logic [63:0] C_HUM_HALF  = 64'd32768;
    localparam logic [63:0] C_HUM_MAX   = 64'd419430400;

    // keep the low word and sign extend it over the full datapath
    function automatic logic [63:0] sx32(logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic logic [63:0] sx16(logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

endpackage

// File: rtl/core/env_sensor_compensation_core.sv
// sensor compensation core: microsequencer, serial multiplier and serial divider
`timescale 1ns / 1ps

// channel   | signals                                   | transfer when
// ----------+-------------------------------------------+------------------------------
// input     | in_valid, in_ready, op, raw_sample        | in_valid && in_ready
// result    | out_valid, out_ready, value, divide_by_zero| out_valid && out_ready
// config    | psel, penable, pwrite, paddr, pwdata, ... | psel && penable && pwrite
//
// all products go through one shift-add multiplier, one bit a cycle: 32-bit for
// temperature and humidity steps, 64-bit for pressure steps; the pressure quotient comes
// from a restoring divider, one bit a cycle for a 64-bit quotient.
// one item is worked on at a time; the next is taken while a result waits in the
// output register. reset clears control state, calibration and fine temperature.

module env_sensor_compensation_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           op,
    input  logic [19:0]          raw_sample,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [32:0]   value,
    output logic                 divide_by_zero,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [esc_pkg::AddrWidth-1:0] paddr,
    input  logic [esc_pkg::DataWidth-1:0] pwdata,
    output logic [esc_pkg::DataWidth-1:0] prdata,
    output logic                 pready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_STEP = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [19:0] raw_reg, raw_next;
    logic [3:0]  step_reg, step_next;
    logic [63:0] ra_reg, ra_next, rb_reg, rb_next, rc_reg, rc_next, rd_reg, rd_next;
    logic [31:0] fine_reg, fine_next;
    logic [63:0] ma_reg, ma_next, mb_reg, mb_next, acc_reg, acc_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        qneg_reg, qneg_next;
    logic [32:0] res_reg, res_next;
    logic        rdz_reg, rdz_next;
    logic        out_valid_reg, out_valid_next;
    logic [32:0] value_reg, value_next;
    logic        dz_reg, dz_next;

    logic [47:0] tcal_reg;
    logic [63:0] pcal_a_reg, pcal_b_reg, hcal_reg;
    logic [15:0] pcal_c_reg;

    // step decode
    logic        st_mul, st_div, st_fin, st_len32, st_dz;
    logic [63:0] st_a, st_b;
    logic [32:0] st_val;
    logic [63:0] tx, ty, tq;

    logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] h1, h2, h3, h4, h5, h6, adc, pv1, hv;
    logic [64:0] rem_sh, rem_diff;
    logic [2:0]  cfg_index;
    logic        cfg_write;

    assign t1  = {48'd0, tcal_reg[15:0]};
    assign t2  = esc_pkg::sx16(tcal_reg[31:16]);
    assign t3  = esc_pkg::sx16(tcal_reg[47:32]);
    assign p1  = {48'd0, pcal_a_reg[15:0]};
    assign p2  = esc_pkg::sx16(pcal_a_reg[31:16]);
    assign p3  = esc_pkg::sx16(pcal_a_reg[47:32]);
    assign p4  = esc_pkg::sx16(pcal_a_reg[63:48]);
    assign p5  = esc_pkg::sx16(pcal_b_reg[15:0]);
    assign p6  = esc_pkg::sx16(pcal_b_reg[31:16]);
    assign p7  = esc_pkg::sx16(pcal_b_reg[47:32]);
    assign p8  = esc_pkg::sx16(pcal_b_reg[63:48]);
    assign p9  = esc_pkg::sx16(pcal_c_reg);
    assign h1  = {56'd0, hcal_reg[7:0]};
    assign h2  = esc_pkg::sx16(hcal_reg[23:8]);
    assign h3  = {56'd0, hcal_reg[31:24]};
    assign h4  = {{52{hcal_reg[43]}}, hcal_reg[43:32]};
    assign h5  = {{52{hcal_reg[55]}}, hcal_reg[55:44]};
    assign h6  = {{56{hcal_reg[63]}}, hcal_reg[63:56]};
    assign adc = {44'd0, raw_reg};
    assign pv1 = esc_pkg::sx32({32'd0, fine_reg}) - esc_pkg::C_PRES_OFS;
    assign hv  = esc_pkg::sx32({32'd0, fine_reg} - esc_pkg::C_HUM_OFS);

    // configuration port
    assign pready    = 1'b1;
    assign cfg_index = paddr[5:3];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_index)
            esc_pkg::REG_TEMP_CAL: prdata = {16'd0, tcal_reg};
            esc_pkg::REG_PRES_A:   prdata = pcal_a_reg;
            esc_pkg::REG_PRES_B:   prdata = pcal_b_reg;
            esc_pkg::REG_PRES_C:   prdata = {48'd0, pcal_c_reg};
            esc_pkg::REG_HUM_CAL:  prdata = hcal_reg;
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tcal_reg   <= '0;
            pcal_a_reg <= '0;
            pcal_b_reg <= '0;
            pcal_c_reg <= '0;
            hcal_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                esc_pkg::REG_TEMP_CAL: tcal_reg   <= pwdata[47:0];
                esc_pkg::REG_PRES_A:   pcal_a_reg <= pwdata;
                esc_pkg::REG_PRES_B:   pcal_b_reg <= pwdata;
                esc_pkg::REG_PRES_C:   pcal_c_reg <= pwdata[15:0];
                esc_pkg::REG_HUM_CAL:  hcal_reg   <= pwdata;
                default:               ;
            endcase
        end
    end

    // one step of the formula: update working registers and launch the next unit or finish
    always_comb
    begin
        st_mul   = 1'b0;
        st_div   = 1'b0;
        st_fin   = 1'b0;
        st_len32 = 1'b0;
        st_dz    = 1'b0;
        st_a     = '0;
        st_b     = '0;
        st_val   = '0;
        tx       = '0;
        ty       = '0;
        tq       = qneg_reg ? (64'd0 - ma_reg) : ma_reg;
        ra_next  = ra_reg;
        rb_next  = rb_reg;
        rc_next  = rc_reg;
        rd_next  = rd_reg;
        fine_next = fine_reg;
        if (state_reg == ST_STEP)
        begin
            unique case (op_reg)
                esc_pkg::OP_TEMP:
                begin
                    st_len32 = 1'b1;
                    st_mul   = 1'b1;
                    unique case (step_reg)
                        4'd0:
                        begin
                            st_a = esc_pkg::sx32((adc >> 3) - (t1 << 1));
                            st_b = t2;
                        end
                        4'd1:
                        begin
                            ra_next = 64'($signed(esc_pkg::sx32(acc_reg)) >>> 11);
                            tx      = esc_pkg::sx32((adc >> 4) - t1);
                            st_a    = tx;
                            st_b    = tx;
                        end
                        4'd2:
                        begin
                            st_a = 64'($signed(esc_pkg::sx32(acc_reg)) >>> 12);
                            st_b = t3;
                        end
                        4'd3:
                        begin
                            tx        = 64'($signed(esc_pkg::sx32(acc_reg)) >>> 14);
                            ty        = esc_pkg::sx32(ra_reg + tx);
                            fine_next = ty[31:0];
                            st_a      = ty;
                            st_b      = 64'd5;
                        end
                        default:
                        begin
                            st_mul = 1'b0;
                            st_fin = 1'b1;
                            tx     = 64'($signed(esc_pkg::sx32(acc_reg + 64'd128)) >>> 8);
                            st_val = tx[32:0];
                        end
                    endcase
                end
                esc_pkg::OP_PRES:
                begin
                    st_mul = 1'b1;
                    unique case (step_reg)
                        4'd0:
                        begin
                            st_a = pv1;
                            st_b = pv1;
                        end
                        4'd1:
                        begin
                            ra_next = acc_reg;
                            st_a    = acc_reg;
                            st_b    = p6;
                        end
                        4'd2:
                        begin
                            rb_next = acc_reg;
                            st_a    = pv1;
                            st_b    = p5;
                        end
                        4'd3:
                        begin
                            rb_next = rb_reg + (acc_reg << 17) + (p4 << 35);
                            st_a    = ra_reg;
                            st_b    = p3;
                        end
                        4'd4:
                        begin
                            rc_next = 64'($signed(acc_reg) >>> 8);
                            st_a    = pv1;
                            st_b    = p2;
                        end
                        4'd5:
                        begin
                            st_a = (64'd1 << 47) + rc_reg + (acc_reg << 12);
                            st_b = p1;
                        end
                        4'd6:
                        begin
                            tx      = 64'($signed(acc_reg) >>> 33);
                            rd_next = tx;
                            if (tx == 64'd0)
                            begin
                                st_mul = 1'b0;
                                st_fin = 1'b1;
                                st_dz  = 1'b1;
                            end
                            st_a = ((esc_pkg::C_PRES_FULL - adc) << 31) - rb_reg;
                            st_b = esc_pkg::C_PRES_MUL;
                        end
                        4'd7:
                        begin
                            st_mul = 1'b0;
                            st_div = 1'b1;
                            st_a   = acc_reg;
                            st_b   = rd_reg;
                        end
                        4'd8:
                        begin
                            ra_next = tq;
                            tx      = 64'($signed(tq) >>> 13);
                            rc_next = tx;
                            st_a    = p9;
                            st_b    = tx;
                        end
                        4'd9:
                        begin
                            st_a = acc_reg;
                            st_b = rc_reg;
                        end
                        4'd10:
                        begin
                            rb_next = 64'($signed(acc_reg) >>> 25);
                            st_a    = p8;
                            st_b    = ra_reg;
                        end
                        default:
                        begin
                            st_mul = 1'b0;
                            st_fin = 1'b1;
                            tx     = ra_reg + rb_reg + 64'($signed(acc_reg) >>> 19);
                            ty     = 64'($signed(tx) >>> 8) + (p7 << 4);
                            st_val = {1'b0, ty[31:0]};
                        end
                    endcase
                end
                esc_pkg::OP_HUM:
                begin
                    st_len32 = 1'b1;
                    st_mul   = 1'b1;
                    unique case (step_reg)
                        4'd0:
                        begin
                            st_a = h5;
                            st_b = hv;
                        end
                        4'd1:
                        begin
                            tx = esc_pkg::sx32(({48'd0, raw_reg[15:0]} << 14) - (h4 << 20)
                                               - acc_reg + esc_pkg::C_HUM_RND);
                            ra_next = 64'($signed(tx) >>> 15);
                            st_a    = hv;
                            st_b    = h6;
                        end
                        4'd2:
                        begin
                            rb_next = 64'($signed(esc_pkg::sx32(acc_reg)) >>> 10);
                            st_a    = hv;
                            st_b    = h3;
                        end
                        4'd3:
                        begin
                            st_a = rb_reg;
                            st_b = 64'($signed(esc_pkg::sx32(acc_reg)) >>> 11)
                                   + esc_pkg::C_HUM_HALF;
                        end
                        4'd4:
                        begin
                            st_a = 64'($signed(esc_pkg::sx32(acc_reg)) >>> 10)
                                   + esc_pkg::C_HUM_BIAS;
                            st_b = h2;
                        end
                        4'd5:
                        begin
                            st_a = ra_reg;
                            st_b = 64'($signed(esc_pkg::sx32(acc_reg + esc_pkg::C_HUM_RND2))
                                       >>> 14);
                        end
                        4'd6:
                        begin
                            tx      = esc_pkg::sx32(acc_reg);
                            rc_next = tx;
                            ty      = 64'($signed(tx) >>> 15);
                            st_a    = ty;
                            st_b    = ty;
                        end
                        4'd7:
                        begin
                            st_a = 64'($signed(esc_pkg::sx32(acc_reg)) >>> 7);
                            st_b = h1;
                        end
                        default:
                        begin
                            st_mul = 1'b0;
                            st_fin = 1'b1;
                            tx = rc_reg - 64'($signed(esc_pkg::sx32(acc_reg)) >>> 4);
                            // negative clamps to zero, then to the full-scale limit
                            priority if (tx[31])
                                ty = 64'd0;
                            else if ({32'd0, tx[31:0]} > esc_pkg::C_HUM_MAX)
                                ty = esc_pkg::C_HUM_MAX;
                            else
                                ty = {32'd0, tx[31:0]};
                            st_val = {13'd0, ty[31:12]};
                        end
                    endcase
                end
                default:
                begin
                    st_fin = 1'b1;
                end
            endcase
        end
    end

    assign rem_sh   = {acc_reg, ma_reg[63]};
    assign rem_diff = rem_sh - {1'b0, mb_reg};

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        raw_next       = raw_reg;
        step_next      = step_reg;
        ma_next        = ma_reg;
        mb_next        = mb_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        qneg_next      = qneg_reg;
        res_next       = res_reg;
        rdz_next       = rdz_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        dz_next        = dz_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = op;
                    raw_next   = raw_sample;
                    step_next  = 4'd0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                priority if (st_fin)
                begin
                    res_next   = st_val;
                    rdz_next   = st_dz;
                    state_next = ST_DONE;
                end
                else if (st_div)
                begin
                    qneg_next  = st_a[63] ^ st_b[63];
                    ma_next    = st_a[63] ? (64'd0 - st_a) : st_a;
                    mb_next    = st_b[63] ? (64'd0 - st_b) : st_b;
                    acc_next   = '0;
                    cnt_next   = 7'd64;
                    state_next = ST_DIV;
                end
                else if (st_mul)
                begin
                    ma_next    = st_a;
                    mb_next    = st_b;
                    acc_next   = '0;
                    cnt_next   = st_len32 ? 7'd32 : 7'd64;
                    state_next = ST_MUL;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_MUL:
            begin
                acc_next = acc_reg + (ma_reg[0] ? mb_reg : 64'd0);
                ma_next  = ma_reg >> 1;
                mb_next  = mb_reg << 1;
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = ST_STEP;
                end
            end
            ST_DIV:
            begin
                // restoring division: remainder in acc, quotient shifts into ma
                if (!rem_diff[64])
                begin
                    acc_next = rem_diff[63:0];
                    ma_next  = {ma_reg[62:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh[63:0];
                    ma_next  = {ma_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    step_next  = step_reg + 4'd1;
                    state_next = ST_STEP;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_reg;
                    dz_next        = rdz_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            fine_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            fine_reg      <= fine_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        raw_reg   <= raw_next;
        ra_reg    <= ra_next;
        rb_reg    <= rb_next;
        rc_reg    <= rc_next;
        rd_reg    <= rd_next;
        ma_reg    <= ma_next;
        mb_reg    <= mb_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        qneg_reg  <= qneg_next;
        res_reg   <= res_next;
        rdz_reg   <= rdz_next;
        value_reg <= value_next;
        dz_reg    <= dz_next;
    end

    assign in_ready       = (state_reg == ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign value          = $signed(value_reg);
    assign divide_by_zero = dz_reg;

endmodule

// File: tb/tb.sv
// self-checking testbench for the sensor compensation core
`timescale 1ns / 1ps

module tb;

    localparam int WatchLimit = 20000;
    localparam int TailCycles = 1000;
    localparam int PhaseItems = 200;
    localparam int NumPhases  = 7;
    localparam int CfgRow     = 6;

    typedef struct packed {
        logic [32:0] val;
        logic        dz;
    } result_t;

    typedef struct {
        logic [1:0]  op;
        logic [19:0] raw;
        bit          typed;
        logic [32:0] val;
        logic        dz;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid, in_ready;
    logic [1:0] op;
    logic [19:0] raw_sample;
    logic out_valid, out_ready;
    logic signed [32:0] value;
    logic divide_by_zero;
    logic psel, penable, pwrite;
    logic [esc_pkg::AddrWidth-1:0] paddr;
    logic [esc_pkg::DataWidth-1:0] pwdata, prdata;
    logic pready;

    // typed expectation travelling with the current input transfer
    bit          cur_typed;
    logic [32:0] cur_val;
    logic        cur_dz;

    // predictor copy of calibration and fine temperature
    logic [63:0] cal_t, cal_pa, cal_pb, cal_pc, cal_h;
    logic [31:0] fine_t;

    result_t pending_q[$];
    int errors;
    int n_results;
    int n_op[4];
    int n_dz;
    int quiet_cycles = 0;
    int stall_left;
    bit no_idle;

    env_sensor_compensation_core u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .op(op), .raw_sample(raw_sample),
        .out_valid(out_valid), .out_ready(out_ready), .value(value),
        .divide_by_zero(divide_by_zero),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] asr32(logic [31:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] asr64(logic [63:0] x, int n);
        return $signed(x) >>> n;
    endfunction

    function automatic logic [63:0] sext16(logic [15:0] x);
        return {{48{x[15]}}, x};
    endfunction

    function automatic logic [32:0] temp_compensate(logic [19:0] adc);
        logic [31:0] a32, t1, t2, t3, a, d, b;
        a32 = {12'b0, adc};
        t1 = {16'b0, cal_t[15:0]};
        t2 = {{16{cal_t[31]}}, cal_t[31:16]};
        t3 = {{16{cal_t[47]}}, cal_t[47:32]};
        a = asr32(((a32 >> 3) - (t1 << 1)) * t2, 11);
        d = (a32 >> 4) - t1;
        b = asr32(asr32(d * d, 12) * t3, 14);
        fine_t = a + b;
        a = asr32(fine_t * 32'd5 + 32'd128, 8);
        return {a[31], a};
    endfunction

    function automatic result_t pres_compensate(logic [19:0] adc);
        logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] v1, v2, p, num, ma, mb, q;
        result_t r;
        p1 = {48'b0, cal_pa[15:0]};
        p2 = sext16(cal_pa[31:16]);
        p3 = sext16(cal_pa[47:32]);
        p4 = sext16(cal_pa[63:48]);
        p5 = sext16(cal_pb[15:0]);
        p6 = sext16(cal_pb[31:16]);
        p7 = sext16(cal_pb[47:32]);
        p8 = sext16(cal_pb[63:48]);
        p9 = sext16(cal_pc[15:0]);
        v1 = {{32{fine_t[31]}}, fine_t} - 64'd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) << 17);
        v2 = v2 + (p4 << 35);
        v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
        v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
        if (v1 == 64'd0)
        begin
            r.val = '0;
            r.dz = 1'b1;
            return r;
        end
        p = 64'd1048576 - {44'b0, adc};
        num = ((p << 31) - v2) * 64'd3125;
        // signed divide on magnitudes, truncating toward zero
        ma = num[63] ? -num : num;
        mb = v1[63] ? -v1 : v1;
        q = ma / mb;
        p = (num[63] != v1[63]) ? -q : q;
        v1 = asr64(p9 * asr64(p, 13) * asr64(p, 13), 25);
        v2 = asr64(p8 * p, 19);
        p = asr64(p + v1 + v2, 8) + (p7 << 4);
        r.val = {1'b0, p[31:0]};
        r.dz = 1'b0;
        return r;
    endfunction

    function automatic logic [32:0] hum_compensate(logic [19:0] adc);
        logic [31:0] h1, h2, h3, h4, h5, h6, v, x, y;
        h1 = {24'b0, cal_h[7:0]};
        h2 = {{16{cal_h[23]}}, cal_h[23:8]};
        h3 = {24'b0, cal_h[31:24]};
        h4 = {{20{cal_h[43]}}, cal_h[43:32]};
        h5 = {{20{cal_h[55]}}, cal_h[55:44]};
        h6 = {{24{cal_h[63]}}, cal_h[63:56]};
        v = fine_t - 32'd76800;
        x = asr32(({16'b0, adc[15:0]} << 14) - (h4 << 20) - h5 * v + 32'd16384, 15);
        y = asr32(asr32(v * h6, 10) * (asr32(v * h3, 11) + 32'd32768), 10);
        y = asr32((y + 32'd2097152) * h2 + 32'd8192, 14);
        v = x * y;
        x = asr32(v, 15);
        v = v - asr32(asr32(x * x, 7) * h1, 4);
        if (v[31])
            v = 32'd0;
        if (v > 32'd419430400)
            v = 32'd419430400;
        return {1'b0, v >> 12};
    endfunction

    function automatic result_t predict_sample(logic [1:0] o, logic [19:0] raw);
        result_t r;
        r.val = '0;
        r.dz = 1'b0;
        case (o)
            esc_pkg::OP_TEMP: r.val = temp_compensate(raw);
            esc_pkg::OP_PRES: r = pres_compensate(raw);
            esc_pkg::OP_HUM:  r.val = hum_compensate(raw);
            default: ;
        endcase
        return r;
    endfunction

    // input side: record expectation on every accepted transfer
    always @(posedge clk)
    begin
        result_t r;
        if (rst_n && in_valid && in_ready)
        begin
            r = predict_sample(op, raw_sample);
            if (cur_typed)
            begin
                r.val = cur_val;
                r.dz = cur_dz;
            end
            pending_q.push_back(r);
            n_op[op]++;
        end
    end

    // result side: random back-pressure, one assignment of out_ready per edge
    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && out_ready)
        begin
            n = no_idle ? 0 : $urandom_range(0, 8);
            stall_left <= n;
            out_ready <= (n == 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= (stall_left == 1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (divide_by_zero)
                n_dz++;
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result value=%h dz=%b", $time, value,
                         divide_by_zero);
            end
            else
            begin
                e = pending_q.pop_front();
                if (value !== e.val)
                begin
                    errors++;
                    $display("%0t: value mismatch expected=%h actual=%h", $time, e.val, value);
                end
                if (divide_by_zero !== e.dz)
                begin
                    errors++;
                    $display("%0t: divide_by_zero mismatch expected=%b actual=%b", $time,
                             e.dz, divide_by_zero);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic reg_write(input logic [2:0] idx, input logic [63:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= esc_pkg::AddrWidth'(idx) << 3;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            esc_pkg::REG_TEMP_CAL: cal_t = data & 64'hFFFF_FFFF_FFFF;
            esc_pkg::REG_PRES_A:   cal_pa = data;
            esc_pkg::REG_PRES_B:   cal_pb = data;
            esc_pkg::REG_PRES_C:   cal_pc = data & 64'hFFFF;
            esc_pkg::REG_HUM_CAL:  cal_h = data;
            default: ;
        endcase
    endtask

    // one edge first so the last accepted transfer is already queued
    task automatic wait_drained();
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic load_typical();
        reg_write(esc_pkg::REG_TEMP_CAL, {16'hFC18, 16'd26435, 16'd27504});
        reg_write(esc_pkg::REG_PRES_A, {16'd2855, 16'd3024, 16'hD643, 16'd36477});
        reg_write(esc_pkg::REG_PRES_B, {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140});
        reg_write(esc_pkg::REG_PRES_C, 64'd6000);
        reg_write(esc_pkg::REG_HUM_CAL, {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
    endtask

    function automatic logic [63:0] draw_word(int mode);
        case (mode)
            0: return 64'd0;
            1: return '1;
            2: return 64'h7FFF_7FFF_7FFF_7FFF;
            3: return 64'h8000_8000_8000_8000;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_sample(input logic [1:0] o, input logic [19:0] raw, input bit typed,
                               input logic [32:0] ev, input logic ed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        raw_sample <= raw;
        cur_typed <= typed;
        cur_val <= ev;
        cur_dz <= ed;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [19:0] draw_raw(logic [1:0] o);
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
            return 20'd0;
        if (k == 1)
            return 20'hFFFFF;
        // realistic readings around a room-temperature sample
        if (k < 6 && o == esc_pkg::OP_TEMP)
            return 20'd519888 + 20'($urandom_range(0, 40000)) - 20'd20000;
        if (k < 6 && o == esc_pkg::OP_PRES)
            return 20'd415148 + 20'($urandom_range(0, 80000)) - 20'd40000;
        if (k < 6 && o == esc_pkg::OP_HUM)
            return 20'($urandom_range(20000, 40000));
        return 20'($urandom);
    endfunction

    stim_row_t rows[] = '{
        // calibration still at reset
        '{esc_pkg::OP_TEMP, 20'd519888, 1'b1, 33'd0, 1'b0},
        '{esc_pkg::OP_PRES, 20'd415148, 1'b1, 33'd0, 1'b1},
        '{esc_pkg::OP_HUM,  20'hFFFFF,  1'b1, 33'd0, 1'b0},
        '{esc_pkg::OP_NONE, 20'hFFFFF,  1'b1, 33'd0, 1'b0},
        '{esc_pkg::OP_PRES, 20'd0,      1'b1, 33'd0, 1'b1},
        '{esc_pkg::OP_TEMP, 20'hFFFFF,  1'b1, 33'd0, 1'b0},
        // typical calibration from here on
        '{esc_pkg::OP_TEMP, 20'd519888, 1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_PRES, 20'd415148, 1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_HUM,  20'd30000,  1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_HUM,  20'hF7530,  1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_NONE, 20'd12345,  1'b1, 33'd0, 1'b0},
        '{esc_pkg::OP_PRES, 20'd0,      1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_PRES, 20'hFFFFF,  1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_HUM,  20'd0,      1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_HUM,  20'h0FFFF,  1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_TEMP, 20'd0,      1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_PRES, 20'd300000, 1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_HUM,  20'd40000,  1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_TEMP, 20'hFFFFF,  1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_PRES, 20'd500000, 1'b0, 33'd0, 1'b0},
        '{esc_pkg::OP_HUM,  20'd25000,  1'b0, 33'd0, 1'b0}
    };

    initial
    begin
        logic [1:0] o;
        int k;
        errors = 0;
        n_results = 0;
        n_dz = 0;
        no_idle = 1'b0;
        n_op = '{0, 0, 0, 0};
        cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0; cal_h = '0;
        fine_t = '0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        op <= esc_pkg::OP_TEMP;
        raw_sample <= '0;
        cur_typed <= 1'b0;
        cur_val <= '0;
        cur_dz <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            if (i == CfgRow)
            begin
                in_valid <= 1'b0;
                wait_drained();
                load_typical();
            end
            send_sample(rows[i].op, rows[i].raw, rows[i].typed, rows[i].val, rows[i].dz);
        end

        for (int ph = 0; ph < NumPhases; ph++)
        begin
            in_valid <= 1'b0;
            wait_drained();
            no_idle = (ph == 2 || ph == 5);
            if (ph == 0)
                load_typical();
            else if (ph == 1 || ph == 2)
            begin
                // all-zero then all-ones calibration
                for (int r = 0; r < 5; r++)
                    reg_write(3'(r), draw_word(ph - 1));
            end
            else
            begin
                for (int r = 0; r < 5; r++)
                    reg_write(3'(r), draw_word($urandom_range(0, 7)));
            end
            for (int n = 0; n < PhaseItems; n++)
            begin
                k = $urandom_range(0, 19);
                // a random mix of temperature, pressure and humidity; one in twenty is the unused op
                o = (k == 0) ? esc_pkg::OP_NONE : 2'(k % 3);
                send_sample(o, draw_raw(o), 1'b0, '0, 1'b0);
            end
        end
        in_valid <= 1'b0;
        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (pending_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d results never arrived", $time, pending_q.size());
        end
        $display("covered %0d temperature, %0d pressure, %0d humidity, %0d unused-op samples",
                 n_op[0], n_op[1], n_op[2], n_op[3]);
        $display("%0d results checked, %0d with zero divisor, %0d errors", n_results, n_dz,
                 errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

// File: sim.f
rtl/core/esc_pkg.sv
rtl/core/env_sensor_compensation_core.sv
tb/tb.sv
